>>> hdl/ibvlc_pkg.sv
// ----------------------------------------------------------------------------
// ibvlc_pkg: shared types and constants of the intra block vlc decoder
// operation and result codes, vlc table lookups, result record
// ----------------------------------------------------------------------------
package ibvlc_pkg;

    localparam logic [2:0] OP_DC_Y  = 3'd0;
    localparam logic [2:0] OP_DC_CB = 3'd1;
    localparam logic [2:0] OP_DC_CR = 3'd2;
    localparam logic [2:0] OP_AC    = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    localparam logic [2:0] KIND_DC  = 3'd0;
    localparam logic [2:0] KIND_AC  = 3'd1;
    localparam logic [2:0] KIND_EOB = 3'd2;
    localparam logic [2:0] KIND_ERR = 3'd3;
    localparam logic [2:0] KIND_CLR = 3'd4;

    localparam int ESC_BITS = 22;

    typedef struct packed {
        logic [4:0]        bits_consumed;
        logic signed [15:0] dc_value;
        logic signed [9:0] level_value;
        logic [5:0]        run_length;
        logic [2:0]        kind;
    } result_t;

    // ac table entry: hit, code length, run, level
    typedef struct packed {
        logic       hit;
        logic [4:0] len;
        logic [5:0] run;
        logic [5:0] lvl;
    } ac_entry_t;

    // ac lookup on the leading 16 window bits
    function automatic ac_entry_t ac_lookup(input logic [15:0] w);
        ac_entry_t e;
        e = '{hit: 1'b1, len: 5'd0, run: 6'd0, lvl: 6'd0};
        priority casez (w)
            16'b11??????????????: e = '{1'b1, 5'd2, 6'd0, 6'd1};
            16'b011?????????????: e = '{1'b1, 5'd3, 6'd1, 6'd1};
            16'b0100????????????: e = '{1'b1, 5'd4, 6'd0, 6'd2};
            16'b0101????????????: e = '{1'b1, 5'd4, 6'd2, 6'd1};
            16'b00101???????????: e = '{1'b1, 5'd5, 6'd0, 6'd3};
            16'b00110???????????: e = '{1'b1, 5'd5, 6'd4, 6'd1};
            16'b00111???????????: e = '{1'b1, 5'd5, 6'd3, 6'd1};
            16'b000100??????????: e = '{1'b1, 5'd6, 6'd7, 6'd1};
            16'b000101??????????: e = '{1'b1, 5'd6, 6'd6, 6'd1};
            16'b000110??????????: e = '{1'b1, 5'd6, 6'd1, 6'd2};
            16'b000111??????????: e = '{1'b1, 5'd6, 6'd5, 6'd1};
            16'b0000100?????????: e = '{1'b1, 5'd7, 6'd2, 6'd2};
            16'b0000101?????????: e = '{1'b1, 5'd7, 6'd9, 6'd1};
            16'b0000110?????????: e = '{1'b1, 5'd7, 6'd0, 6'd4};
            16'b0000111?????????: e = '{1'b1, 5'd7, 6'd8, 6'd1};
            16'b00100000????????: e = '{1'b1, 5'd8, 6'd13, 6'd1};
            16'b00100001????????: e = '{1'b1, 5'd8, 6'd0, 6'd6};
            16'b00100010????????: e = '{1'b1, 5'd8, 6'd12, 6'd1};
            16'b00100011????????: e = '{1'b1, 5'd8, 6'd11, 6'd1};
            16'b00100100????????: e = '{1'b1, 5'd8, 6'd3, 6'd2};
            16'b00100101????????: e = '{1'b1, 5'd8, 6'd1, 6'd3};
            16'b00100110????????: e = '{1'b1, 5'd8, 6'd0, 6'd5};
            16'b00100111????????: e = '{1'b1, 5'd8, 6'd10, 6'd1};
            16'b0000001000??????: e = '{1'b1, 5'd10, 6'd16, 6'd1};
            16'b0000001001??????: e = '{1'b1, 5'd10, 6'd5, 6'd2};
            16'b0000001010??????: e = '{1'b1, 5'd10, 6'd0, 6'd7};
            16'b0000001011??????: e = '{1'b1, 5'd10, 6'd2, 6'd3};
            16'b0000001100??????: e = '{1'b1, 5'd10, 6'd1, 6'd4};
            16'b0000001101??????: e = '{1'b1, 5'd10, 6'd15, 6'd1};
            16'b0000001110??????: e = '{1'b1, 5'd10, 6'd14, 6'd1};
            16'b0000001111??????: e = '{1'b1, 5'd10, 6'd4, 6'd2};
            16'b000000010000????: e = '{1'b1, 5'd12, 6'd0, 6'd11};
            16'b000000010001????: e = '{1'b1, 5'd12, 6'd8, 6'd2};
            16'b000000010010????: e = '{1'b1, 5'd12, 6'd4, 6'd3};
            16'b000000010011????: e = '{1'b1, 5'd12, 6'd0, 6'd10};
            16'b000000010100????: e = '{1'b1, 5'd12, 6'd2, 6'd4};
            16'b000000010101????: e = '{1'b1, 5'd12, 6'd7, 6'd2};
            16'b000000010110????: e = '{1'b1, 5'd12, 6'd21, 6'd1};
            16'b000000010111????: e = '{1'b1, 5'd12, 6'd20, 6'd1};
            16'b000000011000????: e = '{1'b1, 5'd12, 6'd0, 6'd9};
            16'b000000011001????: e = '{1'b1, 5'd12, 6'd19, 6'd1};
            16'b000000011010????: e = '{1'b1, 5'd12, 6'd18, 6'd1};
            16'b000000011011????: e = '{1'b1, 5'd12, 6'd1, 6'd5};
            16'b000000011100????: e = '{1'b1, 5'd12, 6'd3, 6'd3};
            16'b000000011101????: e = '{1'b1, 5'd12, 6'd0, 6'd8};
            16'b000000011110????: e = '{1'b1, 5'd12, 6'd6, 6'd2};
            16'b000000011111????: e = '{1'b1, 5'd12, 6'd17, 6'd1};
            16'b0000000010000???: e = '{1'b1, 5'd13, 6'd10, 6'd2};
            16'b0000000010001???: e = '{1'b1, 5'd13, 6'd9, 6'd2};
            16'b0000000010010???: e = '{1'b1, 5'd13, 6'd5, 6'd3};
            16'b0000000010011???: e = '{1'b1, 5'd13, 6'd3, 6'd4};
            16'b0000000010100???: e = '{1'b1, 5'd13, 6'd2, 6'd5};
            16'b0000000010101???: e = '{1'b1, 5'd13, 6'd1, 6'd7};
            16'b0000000010110???: e = '{1'b1, 5'd13, 6'd1, 6'd6};
            16'b0000000010111???: e = '{1'b1, 5'd13, 6'd0, 6'd15};
            16'b0000000011000???: e = '{1'b1, 5'd13, 6'd0, 6'd14};
            16'b0000000011001???: e = '{1'b1, 5'd13, 6'd0, 6'd13};
            16'b0000000011010???: e = '{1'b1, 5'd13, 6'd0, 6'd12};
            16'b0000000011011???: e = '{1'b1, 5'd13, 6'd26, 6'd1};
            16'b0000000011100???: e = '{1'b1, 5'd13, 6'd25, 6'd1};
            16'b0000000011101???: e = '{1'b1, 5'd13, 6'd24, 6'd1};
            16'b0000000011110???: e = '{1'b1, 5'd13, 6'd23, 6'd1};
            16'b0000000011111???: e = '{1'b1, 5'd13, 6'd22, 6'd1};
            16'b00000000010000??: e = '{1'b1, 5'd14, 6'd0, 6'd31};
            16'b00000000010001??: e = '{1'b1, 5'd14, 6'd0, 6'd30};
            16'b00000000010010??: e = '{1'b1, 5'd14, 6'd0, 6'd29};
            16'b00000000010011??: e = '{1'b1, 5'd14, 6'd0, 6'd28};
            16'b00000000010100??: e = '{1'b1, 5'd14, 6'd0, 6'd27};
            16'b00000000010101??: e = '{1'b1, 5'd14, 6'd0, 6'd26};
            16'b00000000010110??: e = '{1'b1, 5'd14, 6'd0, 6'd25};
            16'b00000000010111??: e = '{1'b1, 5'd14, 6'd0, 6'd24};
            16'b00000000011000??: e = '{1'b1, 5'd14, 6'd0, 6'd23};
            16'b00000000011001??: e = '{1'b1, 5'd14, 6'd0, 6'd22};
            16'b00000000011010??: e = '{1'b1, 5'd14, 6'd0, 6'd21};
            16'b00000000011011??: e = '{1'b1, 5'd14, 6'd0, 6'd20};
            16'b00000000011100??: e = '{1'b1, 5'd14, 6'd0, 6'd19};
            16'b00000000011101??: e = '{1'b1, 5'd14, 6'd0, 6'd18};
            16'b00000000011110??: e = '{1'b1, 5'd14, 6'd0, 6'd17};
            16'b00000000011111??: e = '{1'b1, 5'd14, 6'd0, 6'd16};
            16'b000000000010000?: e = '{1'b1, 5'd15, 6'd0, 6'd40};
            16'b000000000010001?: e = '{1'b1, 5'd15, 6'd0, 6'd39};
            16'b000000000010010?: e = '{1'b1, 5'd15, 6'd0, 6'd38};
            16'b000000000010011?: e = '{1'b1, 5'd15, 6'd0, 6'd37};
            16'b000000000010100?: e = '{1'b1, 5'd15, 6'd0, 6'd36};
            16'b000000000010101?: e = '{1'b1, 5'd15, 6'd0, 6'd35};
            16'b000000000010110?: e = '{1'b1, 5'd15, 6'd0, 6'd34};
            16'b000000000010111?: e = '{1'b1, 5'd15, 6'd0, 6'd33};
            16'b000000000011000?: e = '{1'b1, 5'd15, 6'd0, 6'd32};
            16'b000000000011001?: e = '{1'b1, 5'd15, 6'd1, 6'd14};
            16'b000000000011010?: e = '{1'b1, 5'd15, 6'd1, 6'd13};
            16'b000000000011011?: e = '{1'b1, 5'd15, 6'd1, 6'd12};
            16'b000000000011100?: e = '{1'b1, 5'd15, 6'd1, 6'd11};
            16'b000000000011101?: e = '{1'b1, 5'd15, 6'd1, 6'd10};
            16'b000000000011110?: e = '{1'b1, 5'd15, 6'd1, 6'd9};
            16'b000000000011111?: e = '{1'b1, 5'd15, 6'd1, 6'd8};
            16'b0000000000010000: e = '{1'b1, 5'd16, 6'd1, 6'd18};
            16'b0000000000010001: e = '{1'b1, 5'd16, 6'd1, 6'd17};
            16'b0000000000010010: e = '{1'b1, 5'd16, 6'd1, 6'd16};
            16'b0000000000010011: e = '{1'b1, 5'd16, 6'd1, 6'd15};
            16'b0000000000010100: e = '{1'b1, 5'd16, 6'd6, 6'd3};
            16'b0000000000010101: e = '{1'b1, 5'd16, 6'd16, 6'd2};
            16'b0000000000010110: e = '{1'b1, 5'd16, 6'd15, 6'd2};
            16'b0000000000010111: e = '{1'b1, 5'd16, 6'd14, 6'd2};
            16'b0000000000011000: e = '{1'b1, 5'd16, 6'd13, 6'd2};
            16'b0000000000011001: e = '{1'b1, 5'd16, 6'd12, 6'd2};
            16'b0000000000011010: e = '{1'b1, 5'd16, 6'd11, 6'd2};
            16'b0000000000011011: e = '{1'b1, 5'd16, 6'd31, 6'd1};
            16'b0000000000011100: e = '{1'b1, 5'd16, 6'd30, 6'd1};
            16'b0000000000011101: e = '{1'b1, 5'd16, 6'd29, 6'd1};
            16'b0000000000011110: e = '{1'b1, 5'd16, 6'd28, 6'd1};
            16'b0000000000011111: e = '{1'b1, 5'd16, 6'd27, 6'd1};
            default:              e = '{1'b0, 5'd0, 6'd0, 6'd0};
        endcase
        return e;
    endfunction

    // dc size prefix: hit, prefix length, size
    typedef struct packed {
        logic       hit;
        logic [3:0] len;
        logic [3:0] size;
    } dc_entry_t;

    function automatic dc_entry_t dc_lookup(input logic [7:0] w, input logic chroma);
        dc_entry_t e;
        e = '{1'b0, 4'd0, 4'd0};
        if (chroma)
        begin
            priority casez (w)
                8'b00??????: e = '{1'b1, 4'd2, 4'd0};
                8'b01??????: e = '{1'b1, 4'd2, 4'd1};
                8'b10??????: e = '{1'b1, 4'd2, 4'd2};
                8'b110?????: e = '{1'b1, 4'd3, 4'd3};
                8'b1110????: e = '{1'b1, 4'd4, 4'd4};
                8'b11110???: e = '{1'b1, 4'd5, 4'd5};
                8'b111110??: e = '{1'b1, 4'd6, 4'd6};
                8'b1111110?: e = '{1'b1, 4'd7, 4'd7};
                8'b11111110: e = '{1'b1, 4'd8, 4'd8};
                default:     e = '{1'b0, 4'd0, 4'd0};
            endcase
        end
        else
        begin
            priority casez (w)
                8'b100?????: e = '{1'b1, 4'd3, 4'd0};
                8'b00??????: e = '{1'b1, 4'd2, 4'd1};
                8'b01??????: e = '{1'b1, 4'd2, 4'd2};
                8'b101?????: e = '{1'b1, 4'd3, 4'd3};
                8'b110?????: e = '{1'b1, 4'd3, 4'd4};
                8'b1110????: e = '{1'b1, 4'd4, 4'd5};
                8'b11110???: e = '{1'b1, 4'd5, 4'd6};
                8'b111110??: e = '{1'b1, 4'd6, 4'd7};
                8'b1111110?: e = '{1'b1, 4'd7, 4'd8};
                default:     e = '{1'b0, 4'd0, 4'd0};
            endcase
        end
        return e;
    endfunction

endpackage

>>> hdl/intra_block_vlc_symbol_decoder_top.sv
// ----------------------------------------------------------------------------
// intra_block_vlc_symbol_decoder_top: dc size / ac run-level vlc decoder
// one symbol per request, one result per request
// ----------------------------------------------------------------------------
// path: a request passes the input register, then the result register
// throughput: one request per cycle, set by the single-pass table match
// stalls only when the result register is full and not taken
// reset: predictors zero, chroma table disabled, both stages empty
module intra_block_vlc_symbol_decoder_top #(
    parameter int WINDOW_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        chroma_dc_table_enable_we,
    input  logic        chroma_dc_table_enable_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // bit_window[WINDOW_BITS-1:0], bits_left, zero fill
    input  logic [((WINDOW_BITS + 5 + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // op[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // run_length[5:0], level_value[15:6], dc_value[31:16],
    // bits_consumed[36:32], zero fill
    output logic [39:0] m_axis_tdata,
    // kind[2:0]
    output logic [2:0]  m_axis_tuser
);
    import ibvlc_pkg::*;

    localparam int LW = $clog2(WINDOW_BITS + 1);

    logic                   cfg_chroma_reg;
    logic                   in_valid_reg;
    logic [2:0]             op_reg;
    logic [WINDOW_BITS-1:0] win_reg;
    logic [LW-1:0]          left_reg;
    logic                   out_valid_reg;
    result_t                res_reg, res_next;
    logic [15:0]            pred_reg [3];
    logic [15:0]            pred_sel;
    logic [15:0]            pred_new;
    logic                   adv;
    logic [4:0]             left_in;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_chroma_reg <= 1'b0;
        else if (chroma_dc_table_enable_we)
            cfg_chroma_reg <= chroma_dc_table_enable_wdata;
    end

    assign adv = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || adv;
    assign left_in = s_axis_tdata[WINDOW_BITS + 4 -: 5];

    // input register, bits_left saturated
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            op_reg  <= s_axis_tuser;
            win_reg <= s_axis_tdata[WINDOW_BITS - 1:0];
            if (32'(left_in) > WINDOW_BITS)
                left_reg <= LW'(WINDOW_BITS);
            else
                left_reg <= LW'(left_in);
        end
    end

    // decode
    ac_entry_t         ace;
    dc_entry_t         dce;
    logic [8:0]        dc_raw;
    logic [9:0]        dc_diff;
    logic [4:0]        ac_sign_pos;
    logic [5:0]        ac_lvl_neg;
    logic [4:0]        dc_used;
    logic [1:0]        comp;
    logic [31:0]       wide;
    logic [31:0]       after_pre;

    assign wide = 32'(win_reg) << (32 - WINDOW_BITS);
    assign comp = op_reg[1:0];

    always_comb
    begin
        res_next = '0;
        pred_new = '0;
        pred_sel = pred_reg[0];
        dc_raw = '0;
        dc_diff = '0;
        dc_used = 5'd2;
        ace = ac_lookup(wide[31:16]);
        dce = dc_lookup(wide[31:24], cfg_chroma_reg && (op_reg != OP_DC_Y));
        ac_sign_pos = 5'd31 - ace.len;
        ac_lvl_neg = '0;
        after_pre = wide << dce.len;
        unique case (op_reg)
            OP_DC_Y, OP_DC_CB, OP_DC_CR:
            begin
                pred_sel = pred_reg[comp];
                if (dce.hit && 32'(dce.len) <= 32'(left_reg))
                begin
                    dc_used = 5'(dce.len);
                    if (dce.size != 4'd0 && 32'(dce.len) + 32'(dce.size) <= 32'(left_reg))
                    begin
                        dc_raw = 9'(after_pre[31:23] >> (4'd9 - dce.size));
                        if (after_pre[31])
                            dc_diff = 10'(dc_raw);
                        else
                            dc_diff = 10'(dc_raw) - ((10'd1 << dce.size) - 10'd1);
                        dc_used = 5'(dce.len) + 5'(dce.size);
                    end
                end
                pred_new = pred_sel + {{6{dc_diff[9]}}, dc_diff};
                res_next.kind = KIND_DC;
                res_next.level_value = dc_diff;
                res_next.dc_value = pred_new;
                res_next.bits_consumed = dc_used;
            end
            OP_AC:
            begin
                if (left_reg < LW'(2))
                    res_next.kind = KIND_ERR;
                else if (wide[31:30] == 2'b10)
                begin
                    res_next.kind = KIND_EOB;
                    res_next.bits_consumed = 5'd2;
                end
                else if (left_reg >= LW'(6) && wide[31:26] == 6'b000001)
                begin
                    if (32'(left_reg) < ESC_BITS)
                        res_next.kind = KIND_ERR;
                    else
                    begin
                        res_next.kind = KIND_AC;
                        res_next.run_length = wide[25:20];
                        res_next.level_value = wide[19:10];
                        res_next.bits_consumed = 5'(ESC_BITS);
                    end
                end
                else if (ace.hit && 32'(ace.len) + 32'd1 <= 32'(left_reg))
                begin
                    ac_lvl_neg = 6'd0 - ace.lvl;
                    res_next.kind = KIND_AC;
                    res_next.run_length = ace.run;
                    if (wide[ac_sign_pos])
                        res_next.level_value = {{4{ace.lvl != 6'd0}}, ac_lvl_neg};
                    else
                        res_next.level_value = 10'(ace.lvl);
                    res_next.bits_consumed = ace.len + 5'd1;
                end
                else
                    res_next.kind = KIND_ERR;
            end
            OP_CLEAR:
                res_next.kind = KIND_CLR;
            default:
                res_next.kind = KIND_ERR;
        endcase
    end

    // predictors and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pred_reg[0] <= '0;
            pred_reg[1] <= '0;
            pred_reg[2] <= '0;
        end
        else if (adv)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                if (op_reg == OP_CLEAR)
                begin
                    pred_reg[0] <= '0;
                    pred_reg[1] <= '0;
                    pred_reg[2] <= '0;
                end
                else if (op_reg == OP_DC_Y || op_reg == OP_DC_CB || op_reg == OP_DC_CR)
                    pred_reg[comp] <= pred_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid_reg)
            res_reg <= res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {3'b000, res_reg.bits_consumed, res_reg.dc_value,
                           res_reg.level_value, res_reg.run_length};
    assign m_axis_tuser = res_reg.kind;

    // checks
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("result changed while stalled");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_ERR || m_axis_tuser == KIND_CLR)
        |-> m_axis_tdata[36:32] == 5'd0)
        else $error("error or clear result consumed bits");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("empty input stage not ready");

endmodule

>>> test/tb_checker.sv
// ----------------------------------------------------------------------------
// tb_checker: result predictor and scoreboard for the vlc symbol decoder
// watches both stream channels, predicts each result from accepted requests
// ----------------------------------------------------------------------------
module tb_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [31:0] in_data,
    input  logic [2:0]  in_user,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [39:0] out_data,
    input  logic [2:0]  out_user,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ibvlc_pkg::*;

    typedef struct {
        logic [2:0]  kind;
        logic [5:0]  run;
        logic [9:0]  lvl;
        logic [15:0] dc;
        logic [4:0]  used;
    } symbol_t;

    typedef struct {
        int unsigned len;
        int unsigned code;
        int unsigned size;
    } prefix_t;

    typedef struct {
        int unsigned len;
        int unsigned code;
        int unsigned run;
        int unsigned lvl;
    } rl_code_t;

    symbol_t     expected_symbols[$];
    logic [15:0] dc_pred[3];
    logic        chroma_sel;
    prefix_t     luma_prefix[9];
    prefix_t     chroma_prefix[9];
    rl_code_t    rl_codes[111];

    initial
    begin
        int unsigned raw[444];
        luma_prefix = '{'{3, 4, 0}, '{2, 0, 1}, '{2, 1, 2}, '{3, 5, 3}, '{3, 6, 4},
                        '{4, 14, 5}, '{5, 30, 6}, '{6, 62, 7}, '{7, 126, 8}};
        chroma_prefix = '{'{2, 0, 0}, '{2, 1, 1}, '{2, 2, 2}, '{3, 6, 3}, '{4, 14, 4},
                          '{5, 30, 5}, '{6, 62, 6}, '{7, 126, 7}, '{8, 254, 8}};
        raw = '{2,3,0,1, 3,3,1,1, 4,4,0,2, 4,5,2,1, 5,5,0,3, 5,6,4,1, 5,7,3,1,
                6,4,7,1, 6,5,6,1, 6,6,1,2, 6,7,5,1, 7,4,2,2, 7,5,9,1, 7,6,0,4,
                7,7,8,1, 8,32,13,1, 8,33,0,6, 8,34,12,1, 8,35,11,1, 8,36,3,2,
                8,37,1,3, 8,38,0,5, 8,39,10,1, 10,8,16,1, 10,9,5,2, 10,10,0,7,
                10,11,2,3, 10,12,1,4, 10,13,15,1, 10,14,14,1, 10,15,4,2,
                12,16,0,11, 12,17,8,2, 12,18,4,3, 12,19,0,10, 12,20,2,4,
                12,21,7,2, 12,22,21,1, 12,23,20,1, 12,24,0,9, 12,25,19,1,
                12,26,18,1, 12,27,1,5, 12,28,3,3, 12,29,0,8, 12,30,6,2,
                12,31,17,1, 13,16,10,2, 13,17,9,2, 13,18,5,3, 13,19,3,4,
                13,20,2,5, 13,21,1,7, 13,22,1,6, 13,23,0,15, 13,24,0,14,
                13,25,0,13, 13,26,0,12, 13,27,26,1, 13,28,25,1, 13,29,24,1,
                13,30,23,1, 13,31,22,1, 14,16,0,31, 14,17,0,30, 14,18,0,29,
                14,19,0,28, 14,20,0,27, 14,21,0,26, 14,22,0,25, 14,23,0,24,
                14,24,0,23, 14,25,0,22, 14,26,0,21, 14,27,0,20, 14,28,0,19,
                14,29,0,18, 14,30,0,17, 14,31,0,16, 15,16,0,40, 15,17,0,39,
                15,18,0,38, 15,19,0,37, 15,20,0,36, 15,21,0,35, 15,22,0,34,
                15,23,0,33, 15,24,0,32, 15,25,1,14, 15,26,1,13, 15,27,1,12,
                15,28,1,11, 15,29,1,10, 15,30,1,9, 15,31,1,8, 16,16,1,18,
                16,17,1,17, 16,18,1,16, 16,19,1,15, 16,20,6,3, 16,21,16,2,
                16,22,15,2, 16,23,14,2, 16,24,13,2, 16,25,12,2, 16,26,11,2,
                16,27,31,1, 16,28,30,1, 16,29,29,1, 16,30,28,1, 16,31,27,1};
        for (int i = 0; i < 111; i++)
            rl_codes[i] = '{raw[4*i], raw[4*i+1], raw[4*i+2], raw[4*i+3]};
    end

    // leading n bits starting at bit start of the window, msb first
    function automatic int unsigned peek(logic [23:0] win, int unsigned start,
                                         int unsigned n);
        logic [23:0] sh;
        sh = win << start;
        return sh >> (24 - n);
    endfunction

    function automatic symbol_t decode_symbol(logic [2:0] op, logic [23:0] win,
                                              logic [4:0] left_in);
        symbol_t     s;
        int unsigned left;
        int unsigned raw;
        int unsigned sz;
        logic [15:0] diff;
        prefix_t     p;
        bit          chroma;
        s = '{KIND_ERR, '0, '0, '0, '0};
        left = (left_in > 24) ? 24 : left_in;
        if (op == OP_DC_Y || op == OP_DC_CB || op == OP_DC_CR)
        begin
            chroma = (op != OP_DC_Y) && chroma_sel;
            diff = '0;
            s.used = 5'd2;
            for (int i = 0; i < 9; i++)
            begin
                p = chroma ? chroma_prefix[i] : luma_prefix[i];
                if (p.len > left || peek(win, 0, p.len) != p.code)
                    continue;
                s.used = 5'(p.len);
                if (p.size != 0 && p.len + p.size <= left)
                begin
                    sz = p.size;
                    raw = peek(win, p.len, sz);
                    diff = 16'((raw < (1 << (sz - 1))) ? raw - ((1 << sz) - 1) : raw);
                    s.used = 5'(p.len + sz);
                end
                break;
            end
            dc_pred[op] = dc_pred[op] + diff;
            s.kind = KIND_DC;
            s.lvl = diff[9:0];
            s.dc = dc_pred[op];
        end
        else if (op == OP_AC)
        begin
            if (left < 2)
                return s;
            if (peek(win, 0, 2) == 2)
            begin
                s.kind = KIND_EOB;
                s.used = 5'd2;
                return s;
            end
            if (left >= 6 && peek(win, 0, 6) == 1)
            begin
                if (left >= ESC_BITS)
                    s = '{KIND_AC, 6'(peek(win, 6, 6)), 10'(peek(win, 12, 10)), '0,
                          5'(ESC_BITS)};
                return s;
            end
            foreach (rl_codes[i])
            begin
                if (rl_codes[i].len + 1 > left || peek(win, 0, rl_codes[i].len) != rl_codes[i].code)
                    continue;
                s.kind = KIND_AC;
                s.run = 6'(rl_codes[i].run);
                s.lvl = (peek(win, rl_codes[i].len, 1) != 0) ? 10'(-rl_codes[i].lvl)
                                                             : 10'(rl_codes[i].lvl);
                s.used = 5'(rl_codes[i].len + 1);
                return s;
            end
        end
        else if (op == OP_CLEAR)
        begin
            dc_pred = '{0, 0, 0};
            s.kind = KIND_CLR;
        end
        return s;
    endfunction

    task automatic report(string what, logic [39:0] got, logic [39:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // predict on accepted requests, compare on accepted results
    always @(posedge clk or negedge rst_n)
    begin
        symbol_t w;
        if (!rst_n)
        begin
            dc_pred = '{0, 0, 0};
            chroma_sel = 1'b0;
            fail_count = 0;
            expected_symbols.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_we)
                chroma_sel = cfg_wdata;
            if (in_valid && in_ready)
                expected_symbols.push_back(decode_symbol(in_user, in_data[23:0],
                                                         in_data[28:24]));
            if (out_valid && out_ready)
            begin
                if (expected_symbols.size() == 0)
                    report("unexpected result", out_data, '0);
                else
                begin
                    w = expected_symbols.pop_front();
                    if (out_user != w.kind)
                        report("kind", out_user, w.kind);
                    if (out_data[5:0] != w.run)
                        report("run_length", out_data[5:0], w.run);
                    if (out_data[15:6] != w.lvl)
                        report("level_value", out_data[15:6], w.lvl);
                    if (out_data[31:16] != w.dc)
                        report("dc_value", out_data[31:16], w.dc);
                    if (out_data[36:32] != w.used)
                        report("bits_consumed", out_data[36:32], w.used);
                end
            end
            pending = expected_symbols.size();
        end
    end
endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the intra block vlc symbol decoder
// directed and random requests under random idling (one random phase without), config changes when idle
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ibvlc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;

    // undefined operation codes
    localparam logic [2:0] OP_RSVD_LO = 3'd5;
    localparam logic [2:0] OP_RSVD_HI = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;    // bit_window[23:0], bits_left[28:24]
    logic [2:0]  s_axis_tuser;    // op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;    // run_length, level_value, dc_value, bits_consumed
    logic [2:0]  m_axis_tuser;    // kind
    int          fail_count;
    int          pending;
    int          idle_cycles;
    bit          no_idle;

    intra_block_vlc_symbol_decoder_top DUT (
        .clk(clk), .rst_n(rst_n),
        .chroma_dc_table_enable_we(cfg_we), .chroma_dc_table_enable_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    tb_checker scoreboard (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
        .in_user(s_axis_tuser),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata),
        .out_user(m_axis_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stalls at random
    always @(posedge clk)
        m_axis_tready <= no_idle || ($urandom_range(99) >= 32);

    // watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_we) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // one request; valid stays high into the next request unless idling
    task automatic send(logic [2:0] op, logic [23:0] win, logic [4:0] left);
        bit gap;
        gap = !no_idle && ($urandom_range(99) < 32);
        if (gap)
            s_axis_tvalid <= 1'b0;
        while (gap)
        begin
            @(posedge clk);
            gap = !no_idle && ($urandom_range(99) < 32);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {3'b000, left, win};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // stop sending and wait until every result is out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_chroma_sel(logic v);
        drain();
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // random window; ac: random table code, escape or end of block; dc: mostly ones and a zero
    function automatic logic [23:0] random_window(logic [2:0] op);
        logic [23:0] w;
        int unsigned lz;
        w = 24'($urandom);
        if (op == OP_AC)
        begin
            case ($urandom_range(5))
                0: w[23:22] = 2'b10;
                1: w[23:18] = 6'b000001;
                default:
                begin
                    lz = $urandom_range(11);
                    w = w >> lz;
                    w[23 - lz] = 1'b1;
                end
            endcase
        end
        else if ($urandom_range(3) != 0)
        begin
            lz = $urandom_range(8);
            w = w | (24'hFFFFFF << (24 - lz));
            if (lz < 24)
                w[23 - lz] = 1'b0;
        end
        return w;
    endfunction

    initial
    begin
        logic [2:0] op;
        logic [4:0] left;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        no_idle = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, all ops, special cases
        send(OP_DC_Y, 24'hFFFFFF, 5'd24);
        send(OP_DC_Y, 24'h000000, 5'd31);
        send(OP_DC_Y, 24'hFE0000, 5'd24);
        send(OP_DC_Y, 24'hFF0000, 5'd24);
        send(OP_DC_Y, 24'hFC0000, 5'd7);
        send(OP_DC_CB, 24'h800000, 5'd24);
        send(OP_DC_CR, 24'h400000, 5'd0);
        send(OP_AC, 24'h800000, 5'd2);
        send(OP_AC, 24'hC00000, 5'd1);
        send(OP_AC, 24'hC00000, 5'd2);
        send(OP_AC, 24'h07FFFF, 5'd24);
        send(OP_AC, 24'h07FFFF, 5'd21);
        send(OP_AC, 24'h040200, 5'd22);
        send(OP_AC, 24'h001F00, 5'd17);
        send(OP_AC, 24'h001F00, 5'd16);
        send(OP_AC, 24'h000000, 5'd24);
        send(OP_CLEAR, 24'h123456, 5'd10);
        send(OP_RSVD_LO, 24'hFFFFFF, 5'd24);
        send(OP_RSVD_HI, 24'h000000, 5'd0);
        write_chroma_sel(1'b1);
        send(OP_DC_CB, 24'hFF0000, 5'd24);
        send(OP_DC_CR, 24'hFE0000, 5'd24);
        send(OP_DC_CB, 24'hFF0000, 5'd8);
        send(OP_DC_Y, 24'h800000, 5'd24);

        // random phases, alternating the chroma table select
        for (int phase = 0; phase < 6; phase++)
        begin
            write_chroma_sel(phase[0]);
            no_idle = (phase == 3);
            for (int n = 0; n < 125; n++)
            begin
                op = ($urandom_range(19) == 0) ? 3'($urandom_range(OP_RSVD_HI, OP_CLEAR))
                                               : 3'($urandom_range(OP_AC));
                left = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'd24;
                send(op, ($urandom_range(9) == 0) ? 24'($urandom) : random_window(op),
                     left);
            end
        end
        no_idle = 1'b0;

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

>>> filelist.f
hdl/ibvlc_pkg.sv
hdl/intra_block_vlc_symbol_decoder_top.sv
test/tb_checker.sv
test/tb_top.sv
